// ----- hw/rtl/awl_pkg.sv -----
// Package for the ANSI-aware line wrapper: escape phase type, byte codes and
// the byte classification functions. No dependencies.
package awl_pkg;

  typedef enum logic [2:0] {
    PH_DEFAULT = 3'd0,
    PH_ESCAPE  = 3'd1,
    PH_NF      = 3'd2,
    PH_CSI     = 3'd3,
    PH_FINAL   = 3'd4
  } phase_e;

  localparam int unsigned RowWidthBits = 12;
  localparam logic [RowWidthBits-1:0] RowWidthReset = 12'd80;

  localparam logic [7:0] ChBs       = 8'h08;
  localparam logic [7:0] ChTab      = 8'h09;
  localparam logic [7:0] ChLf       = 8'h0A;
  localparam logic [7:0] ChCr       = 8'h0D;
  localparam logic [7:0] ChEsc      = 8'h1B;
  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] ChInterMax = 8'h2F;
  localparam logic [7:0] ChParamMax = 8'h3F;
  localparam logic [7:0] ChDel      = 8'h7F;
  localparam logic [7:0] ChAsciiEnd = 8'h80;
  localparam logic [7:0] ChContMax  = 8'hBF;
  localparam logic [7:0] ChBracket  = 8'h5B;

  function automatic phase_e next_phase(input phase_e ph, input logic [7:0] b);
    phase_e res;
    res = PH_DEFAULT;
    if (b < ChSpace || b > ChDel) begin
      res = (b == ChEsc) ? PH_ESCAPE : PH_DEFAULT;
    end else begin
      case (ph)
        PH_ESCAPE: begin
          if (b <= ChInterMax) begin
            res = PH_NF;
          end else begin
            res = (b == ChBracket) ? PH_CSI : PH_FINAL;
          end
        end
        PH_NF:  res = PH_FINAL;
        PH_CSI: res = (b <= ChParamMax) ? PH_CSI : PH_FINAL;
        default: res = PH_DEFAULT;
      endcase
    end
    return res;
  endfunction

  function automatic logic is_visible(input logic [7:0] b);
    logic res;
    if (b == ChTab) begin
      res = 1'b1;
    end else if (b < ChAsciiEnd) begin
      res = (b >= ChSpace) && (b < ChDel);
    end else begin
      res = (b > ChContMax);
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/awl_if.sv -----
// Valid/ready stream interfaces for the line wrapper's input and output.
// Depends on nothing.
interface awl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface awl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface

// ----- hw/rtl/ansi_aware_line_wrapper.sv -----
// Top level of the ANSI-aware line wrapper: input register, wrap logic and a
// two-entry result queue. Depends on awl_pkg and the interfaces in awl_if.
//
//   channel   direction  payload                     request taken when
//   in_i      sink       in_byte, end_of_input       valid && ready
//   out_o     source     out_byte, last              valid && ready
//   row_width write-only row_width_i (12 bits)       row_width_we_i
//
// One request is taken per cycle while the result queue has room for its results. It is held
// in the input register, then the wrap logic places its zero, one or two results in the result queue.
// A wrap gives two results: a newline first and then the byte itself.
// Reset clears the queue, the input register and the cursor state, and sets
// the row width to 80. A stalled output fills the queue and then holds input.
module ansi_aware_line_wrapper #(
  parameter int unsigned TAB_STOP    = 8,
  parameter int unsigned COLUMN_BITS = 13
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             row_width_we_i,
  input  logic [awl_pkg::RowWidthBits-1:0] row_width_i,
  awl_in_if.sink                           in_i,
  awl_out_if.source                        out_o
);

  localparam int unsigned CmpBits =
    (COLUMN_BITS > awl_pkg::RowWidthBits) ? COLUMN_BITS : awl_pkg::RowWidthBits;
  localparam logic [COLUMN_BITS:0] ColMax = {1'b0, {COLUMN_BITS{1'b1}}};

  logic [awl_pkg::RowWidthBits-1:0] row_width_q;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_eoi_q;

  awl_pkg::phase_e          phase_q, phase_d;
  logic [COLUMN_BITS-1:0]   column_q, column_d;
  logic                     row_open_q, row_open_d;

  logic [7:0] fifo_byte_q [2];
  logic       fifo_last_q [2];
  logic       rd_ptr_q, wr_ptr_q;
  logic [1:0] count_q, count_d;

  logic [awl_pkg::RowWidthBits-1:0] width;
  awl_pkg::phase_e                  ph;
  logic                             wrap;
  logic [1:0]                       nres;
  logic [7:0]                       res0_byte;
  logic                             res0_last;
  logic [COLUMN_BITS-1:0]           col_src;
  logic [COLUMN_BITS-1:0]           col_moved;
  logic [COLUMN_BITS-1:0]           tab_rem;
  logic [COLUMN_BITS:0]             col_sum;
  logic                             pop;
  logic [1:0]                       count_left;
  logic                             proc_fire;
  logic                             in_fire;

  always_comb begin
    width = (row_width_q == '0) ? awl_pkg::RowWidthBits'(1) : row_width_q;
    ph    = awl_pkg::next_phase(phase_q, in_byte_q);
    wrap  = !in_eoi_q && (in_byte_q != awl_pkg::ChLf) && awl_pkg::is_visible(in_byte_q) &&
            (ph == awl_pkg::PH_DEFAULT) &&
            (CmpBits'(column_q) >= CmpBits'(width));
    col_src = wrap ? '0 : column_q;

    tab_rem = COLUMN_BITS'(col_src % TAB_STOP);
    col_sum = '0;
    if (in_byte_q == awl_pkg::ChTab) begin
      col_sum = {1'b0, col_src} + (COLUMN_BITS+1)'(TAB_STOP) - {1'b0, tab_rem};
    end else if (awl_pkg::is_visible(in_byte_q)) begin
      col_sum = {1'b0, col_src} + (COLUMN_BITS+1)'(1);
    end
    if (in_byte_q == awl_pkg::ChCr) begin
      col_moved = '0;
    end else if (in_byte_q == awl_pkg::ChBs) begin
      col_moved = (col_src != '0) ? col_src - COLUMN_BITS'(1) : '0;
    end else if (in_byte_q == awl_pkg::ChTab || awl_pkg::is_visible(in_byte_q)) begin
      col_moved = (col_sum > ColMax) ? ColMax[COLUMN_BITS-1:0] : col_sum[COLUMN_BITS-1:0];
    end else begin
      col_moved = col_src;
    end

    phase_d    = phase_q;
    column_d   = column_q;
    row_open_d = row_open_q;
    res0_byte  = in_byte_q;
    res0_last  = 1'b1;
    if (in_eoi_q) begin
      nres       = row_open_q ? 2'd1 : 2'd0;
      res0_byte  = awl_pkg::ChLf;
      phase_d    = awl_pkg::PH_DEFAULT;
      column_d   = '0;
      row_open_d = 1'b0;
    end else if (in_byte_q == awl_pkg::ChLf) begin
      nres       = 2'd1;
      phase_d    = awl_pkg::PH_DEFAULT;
      column_d   = '0;
      row_open_d = 1'b0;
    end else if (wrap) begin
      nres       = 2'd2;
      res0_byte  = awl_pkg::ChLf;
      res0_last  = 1'b0;
      phase_d    = ph;
      column_d   = col_moved;
      row_open_d = 1'b1;
    end else begin
      nres       = 2'd1;
      phase_d    = ph;
      if (ph == awl_pkg::PH_DEFAULT) begin
        column_d = col_moved;
      end
      row_open_d = 1'b1;
    end
  end

  assign pop        = out_o.valid && out_o.ready;
  assign count_left = count_q - {1'b0, pop};
  assign proc_fire  = in_valid_q && (nres <= (2'd2 - count_left));
  assign in_i.ready = !in_valid_q || proc_fire;
  assign in_fire    = in_i.valid && in_i.ready;
  assign count_d    = count_left + (proc_fire ? nres : 2'd0);

  assign out_o.valid    = (count_q != 2'd0);
  assign out_o.out_byte = fifo_byte_q[rd_ptr_q];
  assign out_o.last     = fifo_last_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= awl_pkg::RowWidthReset;
      in_valid_q  <= 1'b0;
      phase_q     <= awl_pkg::PH_DEFAULT;
      column_q    <= '0;
      row_open_q  <= 1'b0;
      rd_ptr_q    <= 1'b0;
      wr_ptr_q    <= 1'b0;
      count_q     <= 2'd0;
    end else begin
      if (row_width_we_i) begin
        row_width_q <= row_width_i;
      end
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (proc_fire) begin
        in_valid_q <= 1'b0;
      end
      if (proc_fire) begin
        phase_q    <= phase_d;
        column_q   <= column_d;
        row_open_q <= row_open_d;
        if (nres == 2'd1) begin
          wr_ptr_q <= ~wr_ptr_q;
        end
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= in_i.in_byte;
      in_eoi_q  <= in_i.end_of_input;
    end
    if (proc_fire && nres != 2'd0) begin
      fifo_byte_q[wr_ptr_q] <= res0_byte;
      fifo_last_q[wr_ptr_q] <= res0_last;
      if (nres == 2'd2) begin
        fifo_byte_q[~wr_ptr_q] <= in_byte_q;
        fifo_last_q[~wr_ptr_q] <= 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q != 2'd3)
    else $error("Result queue holds more than two entries.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.last) |-> (out_o.out_byte == awl_pkg::ChLf))
    else $error("First result of a pair is not a newline.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !proc_fire) |=> (in_valid_q && $stable(in_byte_q) && $stable(in_eoi_q)))
    else $error("Held request was lost or changed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != awl_pkg::PH_DEFAULT) |-> row_open_q)
    else $error("Escape sequence open without an open row.");

endmodule

// ----- dv/tb_ansi_aware_line_wrapper.sv -----
// Self-checking testbench for the ANSI-aware line wrapper: a scoreboard class predicts
// each output byte and compares it with the result stream under random flow control.
// Depends on awl_pkg, the stream interfaces in awl_if and the top level of the block.
module tb_ansi_aware_line_wrapper;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] ByteBs     = 8'h08;
  localparam logic [7:0] ByteTab    = 8'h09;
  localparam logic [7:0] ByteLf     = 8'h0A;
  localparam logic [7:0] ByteCr     = 8'h0D;
  localparam logic [7:0] ByteEsc    = 8'h1B;
  localparam logic [7:0] ByteLsb    = 8'h5B;
  localparam int         TabStop    = 8;
  localparam int         ColumnMax  = (1 << 13) - 1;
  localparam int         SettleCycles = 6;
  localparam int         StallLimit = 2000;
  localparam int         SegItems   = 62;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } shown_byte_t;

  class line_wrap_scoreboard;
    shown_byte_t                      shown_q[$];
    logic [awl_pkg::RowWidthBits-1:0] width;
    awl_pkg::phase_e                  phase;
    int                               column;
    bit                               row_open;
    int                               mismatches;

    function new();
      width      = 12'd80;
      phase      = awl_pkg::PH_DEFAULT;
      column     = 0;
      row_open   = 1'b0;
      mismatches = 0;
    endfunction

    function void set_width(input logic [awl_pkg::RowWidthBits-1:0] w);
      width = w;
    endfunction

    function int pending();
      return shown_q.size();
    endfunction

    function awl_pkg::phase_e advance_phase(input awl_pkg::phase_e ph,
                                            input logic [7:0] b);
      if (b < 8'h20 || b > 8'h7F)
        return (b == ByteEsc) ? awl_pkg::PH_ESCAPE : awl_pkg::PH_DEFAULT;
      case (ph)
        awl_pkg::PH_ESCAPE: begin
          if (b <= 8'h2F) return awl_pkg::PH_NF;
          return (b == ByteLsb) ? awl_pkg::PH_CSI : awl_pkg::PH_FINAL;
        end
        awl_pkg::PH_NF:  return awl_pkg::PH_FINAL;
        awl_pkg::PH_CSI: return (b <= 8'h3F) ? awl_pkg::PH_CSI : awl_pkg::PH_FINAL;
        default: return awl_pkg::PH_DEFAULT;
      endcase
    endfunction

    function bit takes_column(input logic [7:0] b);
      if (b == ByteTab) return 1'b1;
      if (b < 8'h80) return (b >= 8'h20) && (b < 8'h7F);
      return b > 8'hBF;
    endfunction

    function int moved_column(input logic [7:0] b, input int c);
      int n;
      n = c;
      if (b == ByteCr) n = 0;
      else if (b == ByteTab) n = c + (TabStop - c % TabStop);
      else if (b == ByteBs) n = (c > 0) ? c - 1 : 0;
      else if (takes_column(b)) n = c + 1;
      return (n > ColumnMax) ? ColumnMax : n;
    endfunction

    function void note_request(input logic [7:0] b, input logic eoi);
      int              eff;
      awl_pkg::phase_e nxt;
      eff = (width == 0) ? 1 : int'(width);
      if (eoi) begin
        if (row_open) shown_q.push_back('{ByteLf, 1'b1});
        phase    = awl_pkg::PH_DEFAULT;
        column   = 0;
        row_open = 1'b0;
        return;
      end
      nxt = advance_phase(phase, b);
      if (b == ByteLf) begin
        shown_q.push_back('{ByteLf, 1'b1});
        phase    = awl_pkg::PH_DEFAULT;
        column   = 0;
        row_open = 1'b0;
        return;
      end
      if (column >= eff && takes_column(b) && nxt == awl_pkg::PH_DEFAULT) begin
        shown_q.push_back('{ByteLf, 1'b0});
        shown_q.push_back('{b, 1'b1});
        column = moved_column(b, 0);
      end else begin
        shown_q.push_back('{b, 1'b1});
        if (nxt == awl_pkg::PH_DEFAULT) column = moved_column(b, column);
      end
      phase    = nxt;
      row_open = 1'b1;
    endfunction

    function void check_result(input logic [7:0] b, input logic last);
      shown_byte_t want;
      if (shown_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result byte %02h last %0b", $time, b, last);
      end else begin
        want = shown_q.pop_front();
        if (want.data !== b || want.last !== last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected byte %02h last %0b, got byte %02h last %0b",
                     $time, want.data, want.last, b, last);
        end
      end
    endfunction

    function void close_out();
      if (shown_q.size() != 0) begin
        $display("%0d expected results never arrived", shown_q.size());
        mismatches += shown_q.size();
      end
    endfunction
  endclass

  logic                             clk_i;
  logic                             rst_ni;
  logic                             row_width_we_i;
  logic [awl_pkg::RowWidthBits-1:0] row_width_i;

  awl_in_if  in_if ();
  awl_out_if out_if ();

  ansi_aware_line_wrapper i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .row_width_we_i (row_width_we_i),
    .row_width_i    (row_width_i),
    .in_i           (in_if),
    .out_o          (out_if)
  );

  line_wrap_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int seg_items;
  int idle_cycles;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.out_byte, out_if.last);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("tb_ansi_aware_line_wrapper failed");
      $finish;
    end
  end

  task automatic send_request(input logic [7:0] b, input logic eoi);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.in_byte      <= b;
    in_if.end_of_input <= eoi;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_request(b, eoi);
    seg_items++;
  endtask

  task automatic wait_for_results(input bit settle);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    if (settle) repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_width(input logic [awl_pkg::RowWidthBits-1:0] w);
    row_width_we_i <= 1'b1;
    row_width_i    <= w;
    @(posedge clk_i);
    row_width_we_i <= 1'b0;
    sb.set_width(w);
  endtask

  task automatic send_group();
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 45) begin
      n = $urandom_range(6, 1);
      repeat (n) send_request(8'($urandom_range(8'h7E, 8'h20)), 1'b0);
    end else if (r < 53) begin
      send_request(ByteTab, 1'b0);
    end else if (r < 58) begin
      send_request($urandom_range(1) ? ByteCr : ByteBs, 1'b0);
    end else if (r < 62) begin
      send_request(ByteLf, 1'b0);
    end else if (r < 65) begin
      send_request(8'($urandom_range(255)), 1'b1);
    end else if (r < 75) begin
      send_request(ByteEsc, 1'b0);
      send_request(ByteLsb, 1'b0);
      n = $urandom_range(3);
      repeat (n) send_request(8'($urandom_range(8'h3F, 8'h30)), 1'b0);
      if ($urandom_range(3) == 0) send_request(8'($urandom_range(8'h2F, 8'h20)), 1'b0);
      send_request(8'($urandom_range(8'h7F, 8'h40)), 1'b0);
    end else if (r < 80) begin
      send_request(ByteEsc, 1'b0);
      n = $urandom_range(2, 1);
      repeat (n) send_request(8'($urandom_range(8'h2F, 8'h20)), 1'b0);
      send_request(8'($urandom_range(8'h7E, 8'h30)), 1'b0);
    end else if (r < 83) begin
      send_request(ByteEsc, 1'b0);
      send_request(8'($urandom_range(8'h7E, 8'h30)), 1'b0);
    end else if (r < 90) begin
      send_request(8'($urandom_range(8'hFF, 8'hC0)), 1'b0);
      n = $urandom_range(3, 1);
      repeat (n) send_request(8'($urandom_range(8'hBF, 8'h80)), 1'b0);
    end else begin
      n = $urandom_range(3, 1);
      repeat (n) send_request(8'($urandom_range(255)), 1'b0);
    end
  endtask

  initial begin
    logic [7:0]                       opening_bytes [] = '{
      8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h09, 8'h7E, 8'h08, 8'h0D, 8'h20,
      8'h0A, 8'h1B, 8'h5B, 8'h33, 8'h31, 8'h6D, 8'h1B, 8'h28, 8'h42, 8'h1B,
      8'h63, 8'hC3, 8'hA9, 8'hFF, 8'h80, 8'h7F, 8'h00
    };
    logic [awl_pkg::RowWidthBits-1:0] seg_widths [12] = '{
      12'd1, 12'd9, 12'd4095, 12'd0, 12'd3, 12'd16,
      12'd80, 12'd5, 12'd40, 12'd2, 12'd12, 12'd7
    };
    bit paused;

    sb                 = new();
    tx_idle_pct        = 16;
    rx_idle_pct        = 59;
    rst_ni             = 1'b0;
    row_width_we_i     = 1'b0;
    row_width_i        = '0;
    in_if.valid        = 1'b0;
    in_if.in_byte      = '0;
    in_if.end_of_input = 1'b0;
    out_if.ready       = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_width(12'd4);
    foreach (opening_bytes[i]) send_request(opening_bytes[i], 1'b0);
    send_request(8'h00, 1'b1);
    send_request(8'hFF, 1'b1);
    wait_for_results(1'b1);

    foreach (seg_widths[s]) begin
      if (s == 4) begin
        tx_idle_pct = 59;
        rx_idle_pct = 16;
      end else if (s == 8) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_width(seg_widths[s]);
      seg_items = 0;
      paused    = 1'b0;
      while (seg_items < SegItems) begin
        send_group();
        if (!paused && seg_items >= SegItems / 2) begin
          wait_for_results(1'b0);
          paused = 1'b1;
        end
      end
      wait_for_results(1'b1);
    end

    sb.close_out();
    if (sb.mismatches == 0) begin
      $display("tb_ansi_aware_line_wrapper passed");
    end else begin
      $display("tb_ansi_aware_line_wrapper failed");
    end
    $finish;
  end

endmodule
